>>> hw/rtl/cls_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cls_pkg
// Shared types and constants for the charlieplexed LED scanner.
// ---------------------------------------------------------------------------
package cls_pkg;

  // Array geometry
  localparam int WIRES  = 5;
  localparam int COMBOS = 25;

  // Field widths fixed by the interface
  localparam int ACT_W = 3;
  localparam int IDX_W = 5;
  localparam int OUT_W = 5;

  // Internal widths derived from the geometry
  localparam int CNT_W = (COMBOS > 1) ? $clog2(COMBOS) : 1;
  localparam int COL_W = (WIRES > 1) ? $clog2(WIRES) : 1;
  localparam int ROW_MAX = (COMBOS - 1) / WIRES;
  localparam int ROW_W = (ROW_MAX > 0) ? $clog2(ROW_MAX + 1) : 1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SET     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ALL_ON  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ALL_OFF = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0] led_index;
    logic [ACT_W-1:0] action;
  } cls_item_t;

  typedef struct packed {
    logic             lit;
    logic [OUT_W-1:0] scan_position;
    logic [OUT_W-1:0] drive_low;
    logic [OUT_W-1:0] drive_high;
  } cls_result_t;

endpackage

>>> hw/rtl/cls_scan_state.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cls_scan_state
// LED bit store, scan counter and wire drive; applies one item per apply
// strobe and presents the result as it stands after that item.
// ---------------------------------------------------------------------------
module cls_scan_state
  import cls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        apply,
  input  cls_item_t   item,
  output cls_result_t result_next
);

  logic [COMBOS-1:0] led_bits;
  logic [COMBOS-1:0] led_bits_next;
  logic [CNT_W-1:0]  scan_cnt;
  logic [CNT_W-1:0]  scan_cnt_next;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_next;
  logic [OUT_W-1:0]  drive_high;
  logic [OUT_W-1:0]  drive_high_next;
  logic [OUT_W-1:0]  drive_low;
  logic [OUT_W-1:0]  drive_low_next;
  logic              lit;
  logic              lit_next;
  logic              pair_ok;

  // Row and column ride along with the counter: no divide needed.
  always_comb begin
    if (32'(scan_cnt) == COMBOS - 1) begin
      scan_cnt_next = '0;
      row_next      = '0;
      col_next      = '0;
    end else begin
      scan_cnt_next = scan_cnt + CNT_W'(1);
      if (32'(col) == WIRES - 1) begin
        col_next = '0;
        row_next = row + ROW_W'(1);
      end else begin
        col_next = col + COL_W'(1);
        row_next = row;
      end
    end
  end

  assign pair_ok = led_bits[scan_cnt_next] && (32'(row_next) != 32'(col_next))
                   && (32'(row_next) < WIRES);

  always_comb begin
    led_bits_next   = led_bits;
    drive_high_next = drive_high;
    drive_low_next  = drive_low;
    lit_next        = lit;
    unique case (item.action)
      ACT_TICK: begin
        lit_next        = pair_ok;
        drive_high_next = pair_ok ? (OUT_W'(1) << row_next) : '0;
        drive_low_next  = pair_ok ? (OUT_W'(1) << col_next) : '0;
      end
      ACT_SET: begin
        for (int i = 0; i < COMBOS; i++) begin
          if (32'(item.led_index) == i) led_bits_next[i] = 1'b1;
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < COMBOS; i++) begin
          if (32'(item.led_index) == i) led_bits_next[i] = 1'b0;
        end
      end
      ACT_ALL_ON:  led_bits_next = '1;
      ACT_ALL_OFF: led_bits_next = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_bits   <= '0;
      scan_cnt   <= '0;
      row        <= '0;
      col        <= '0;
      drive_high <= '0;
      drive_low  <= '0;
      lit        <= 1'b0;
    end else if (apply) begin
      led_bits   <= led_bits_next;
      if (item.action == ACT_TICK) begin
        scan_cnt <= scan_cnt_next;
        row      <= row_next;
        col      <= col_next;
      end
      drive_high <= drive_high_next;
      drive_low  <= drive_low_next;
      lit        <= lit_next;
    end
  end

  always_comb begin
    result_next.drive_high    = drive_high_next;
    result_next.drive_low     = drive_low_next;
    result_next.lit           = lit_next;
    result_next.scan_position = (item.action == ACT_TICK) ? OUT_W'(scan_cnt_next)
                                                           : OUT_W'(scan_cnt);
  end

endmodule

>>> hw/rtl/charlieplex_led_scanner_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// charlieplex_led_scanner_core
// Charlieplexed LED scanner: LED on/off store plus tick-driven wire scan.
// ---------------------------------------------------------------------------
// Channel   Dir  Payload (tdata, low bit first)
// s_axis    in   action[2:0], led_index[7:3]
// m_axis    out  drive_high[4:0], drive_low[9:5], scan_position[14:10], lit[15]
//
// Each item passes through the input register, then through the state update
// into the result register. One item per cycle is sustained while m_axis is
// not stalled; the state update is a counter step and a single bit lookup.
// A stalled output holds its result and the input register; s_axis_tready
// drops only when both registers are full and m_axis is stalled.
// Synchronous reset clears LED bits, scan counter and drive, empties both
// registers.
// ---------------------------------------------------------------------------
module charlieplex_led_scanner_core
  import cls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // action[2:0], led_index[7:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // drive_high[4:0], drive_low[9:5],
                                      // scan_position[14:10], lit[15]
);

  cls_item_t   in_item;
  logic        in_valid;
  cls_result_t result_next;
  cls_result_t result;
  logic        out_valid;
  logic        out_free;
  logic        apply;

  // Output slot frees up when empty or being taken this cycle.
  assign out_free      = !out_valid || m_axis_tready;
  assign apply         = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.action    <= s_axis_tdata[2:0];
      in_item.led_index <= s_axis_tdata[7:3];
    end
  end

  // State update; the result reflects state after the item.
  cls_scan_state u_state (
    .clk         (clk),
    .rst         (rst),
    .apply       (apply),
    .item        (in_item),
    .result_next (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {result.lit, result.scan_position, result.drive_low,
                          result.drive_high};

`ifndef SYNTHESIS
  // At most one wire driven high and at most one driven low.
  a_onehot_drive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($onehot0(m_axis_tdata[4:0]) && $onehot0(m_axis_tdata[9:5])))
    else $error("drive masks not one-hot");

  // The same wire is never driven both ways.
  a_no_short: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[4:0] & m_axis_tdata[9:5]) == 5'd0))
    else $error("wire driven high and low");

  // Both stages full with output stalled: input must be held off.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted into full pipeline");
`endif

endmodule
